>>> hdl/plti_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise-linear table interpolation: shared package
// Request kinds, status codes, controller states and word constants.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PROD_W = 2 * WORD_W;

  localparam logic signed [WORD_W-1:0] X_MOST_POS = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] X_MOST_NEG = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERYY = 2'd2,
    REQ_QUERYZ = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_FEW      = 2'd2,
    ST_ZEROWID  = 2'd3
  } status_e;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SCAN = 11'b000_0000_0010,
    S_RDA  = 11'b000_0000_0100,
    S_RDB  = 11'b000_0000_1000,
    S_RDC  = 11'b000_0001_0000,
    S_CALC = 11'b000_0010_0000,
    S_PREP = 11'b000_0100_0000,
    S_MUL  = 11'b000_1000_0000,
    S_DIVS = 11'b001_0000_0000,
    S_DIVW = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  // Handshake between the controller and the divider.
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

>>> hdl/plti_mem.sv
// ----------------------------------------------------------------------------
// Point memory
// Three synchronous memories for x, y and z, one write and one registered read.
// ----------------------------------------------------------------------------
module plti_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [plti_pkg::WORD_W-1:0] wx_i,
  input  logic [plti_pkg::WORD_W-1:0] wy_i,
  input  logic [plti_pkg::WORD_W-1:0] wz_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [plti_pkg::WORD_W-1:0] rx_o,
  output logic [plti_pkg::WORD_W-1:0] ry_o,
  output logic [plti_pkg::WORD_W-1:0] rz_o
);
  import plti_pkg::*;

  logic [WORD_W-1:0] mem_x [DEPTH];
  logic [WORD_W-1:0] mem_y [DEPTH];
  logic [WORD_W-1:0] mem_z [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
      mem_z[waddr_i] <= wz_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rx_o <= mem_x[raddr_i];
    ry_o <= mem_y[raddr_i];
    rz_o <= mem_z[raddr_i];
  end

endmodule

>>> hdl/plti_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division of 64 by 32 bits, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module plti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  plti_pkg::div_ctl_t          ctl_i,
  output plti_pkg::div_ctl_t          ctl_o,
  input  logic [plti_pkg::PROD_W-1:0] dividend_i,
  input  logic [plti_pkg::WORD_W-1:0] divisor_i,
  output logic [plti_pkg::WORD_W-1:0] quot_o
);
  import plti_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] dsr_q, dsr_d;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   trial;

  // One restoring step per cycle.
  always_comb begin
    rem_sh = {rem_q, quo_q[PROD_W-1]};
    trial  = rem_sh - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[WORD_W]) begin
        rem_d = trial[WORD_W-1:0];
        quo_d = {quo_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WORD_W-1:0];
        quo_d = {quo_q[PROD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign ctl_o.start = busy_q;
  assign ctl_o.done  = done_q;
  assign quot_o      = quo_q[WORD_W-1:0];

endmodule

>>> hdl/piecewise_linear_table_interp_unit.sv
// ----------------------------------------------------------------------------
// Piecewise-linear table interpolation unit
// Point table with linear search and interpolation of y or z in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one request a beat: tuser carries the request kind
// (clear, append, query y, query z), tdata carries x, y and z. The master
// channel returns one beat per request: tdata the value, tuser the status.
// Clear and append go straight to the done state; an append writes one
// memory row unless the table is full. A query searches linearly, one row
// a cycle through the memory read port, then reads the two segment rows and,
// for a non-zero width, multiplies and runs the 64-step serial divider.
// One request is worked on at a time; the next beat is taken as soon as the
// result sits in the output register, even while that beat is stalled.
// A stalled master holds the result and keeps the controller waiting.
// Reset empties the table and the output register; the memory contents are
// left as they are and no clearing pass is needed.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value[31:0]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import plti_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic signed [WORD_W-1:0] least_q, least_d, great_q, great_d;
  logic req_z_q, req_z_d;
  logic signed [WORD_W-1:0] xq_q, xq_d;
  logic [AW-1:0] iss_q, iss_d, chk_q, chk_d, idx_q, idx_d;
  logic chkv_q, chkv_d;
  logic signed [WORD_W-1:0] x0_q, x0_d, v0_q, v0_d, x1_q, x1_d, v1_q, v1_d;
  logic signed [WORD_W:0] dx_q, dx_d, t_q, t_d, dv_q, dv_d;
  logic [WORD_W-1:0] mt_q, mt_d, mdx_q, mdx_d, mdv_q, mdv_d;
  logic neg_q, neg_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic signed [WORD_W-1:0] res_q, res_d;
  status_e stat_q, stat_d;
  logic ov_q, ov_d;
  logic [WORD_W-1:0] od_q, od_d;
  logic [1:0] ou_q, ou_d;

  logic s_acc, out_free;
  logic signed [WORD_W-1:0] in_x, in_y, in_z, xcl, rx_s, rv_s;
  req_e in_req;
  logic we;
  logic [AW-1:0] raddr;
  logic [WORD_W-1:0] rx, ry, rz, quot;
  logic signed [WORD_W+1:0] dxa, ta, sum;
  div_ctl_t div_in, div_out;

  assign in_x   = s_axis_tdata[31:0];
  assign in_y   = s_axis_tdata[63:32];
  assign in_z   = s_axis_tdata[95:64];
  assign in_req = req_e'(s_axis_tuser);
  assign s_axis_tready = (st_q == S_IDLE);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;
  assign we = s_acc && (in_req == REQ_APPEND) && (cnt_q != CW'(TABLE_DEPTH));
  assign rx_s = rx;
  assign rv_s = req_z_q ? rz : ry;
  assign div_in.start = (st_q == S_DIVS);
  assign div_in.done  = 1'b0;

  // Read address for the search and for the two segment rows.
  always_comb begin
    case (st_q)
      S_RDA:   raddr = idx_q - 1'b1;
      S_RDB:   raddr = idx_q;
      default: raddr = iss_q;
    endcase
  end

  // Query x clamped to the range seen since the last clear.
  always_comb begin
    xcl = in_x;
    if (xcl > great_q) xcl = great_q;
    if (xcl < least_q) xcl = least_q;
  end

  plti_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AW-1:0]),
    .wx_i(in_x), .wy_i(in_y), .wz_i(in_z),
    .raddr_i(raddr), .rx_o(rx), .ry_o(ry), .rz_o(rz)
  );

  plti_div u_div (
    .clk_i, .rst_ni, .ctl_i(div_in), .ctl_o(div_out),
    .dividend_i(prod_q), .divisor_i(mdx_q), .quot_o(quot)
  );

  // Controller.
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; least_d = least_q; great_d = great_q;
    req_z_d = req_z_q; xq_d = xq_q; iss_d = iss_q; chk_d = chk_q;
    chkv_d = chkv_q; idx_d = idx_q; x0_d = x0_q; v0_d = v0_q;
    x1_d = x1_q; v1_d = v1_q; dx_d = dx_q; t_d = t_q; dv_d = dv_q;
    mt_d = mt_q; mdx_d = mdx_q; mdv_d = mdv_q; neg_d = neg_q;
    prod_d = prod_q; res_d = res_q; stat_d = stat_q;
    ov_d = ov_q && !m_axis_tready; od_d = od_q; ou_d = ou_q;
    dxa = '0; ta = '0; sum = '0;
    case (st_q)
      S_IDLE: begin
        if (s_acc) begin
          res_d  = '0;
          stat_d = ST_OK;
          st_d   = S_DONE;
          case (in_req)
            REQ_CLEAR: begin
              cnt_d   = '0;
              least_d = X_MOST_POS;
              great_d = X_MOST_NEG;
            end
            REQ_APPEND: begin
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                stat_d = ST_FULL;
              end else begin
                cnt_d = cnt_q + 1'b1;
                if (in_x > great_q) great_d = in_x;
                if (in_x < least_q) least_d = in_x;
              end
            end
            default: begin
              req_z_d = (in_req == REQ_QUERYZ);
              xq_d    = xcl;
              if (cnt_q < CW'(2)) begin
                stat_d = ST_FEW;
              end else begin
                iss_d  = AW'(1);
                chkv_d = 1'b0;
                st_d   = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        iss_d  = iss_q + 1'b1;
        chk_d  = iss_q;
        chkv_d = 1'b1;
        if (chkv_q && ((rx_s >= xq_q) || (CW'(chk_q) == cnt_q - 1'b1))) begin
          idx_d = chk_q;
          st_d  = S_RDA;
        end
      end
      S_RDA: st_d = S_RDB;
      S_RDB: begin
        x0_d = rx_s;
        v0_d = rv_s;
        st_d = S_RDC;
      end
      S_RDC: begin
        x1_d = rx_s;
        v1_d = rv_s;
        st_d = S_CALC;
      end
      S_CALC: begin
        dx_d = {x1_q[WORD_W-1], x1_q} - {x0_q[WORD_W-1], x0_q};
        t_d  = {xq_q[WORD_W-1], xq_q} - {x0_q[WORD_W-1], x0_q};
        dv_d = {v1_q[WORD_W-1], v1_q} - {v0_q[WORD_W-1], v0_q};
        st_d = S_PREP;
      end
      S_PREP: begin
        if (dx_q == '0) begin
          res_d  = v0_q;
          stat_d = ST_ZEROWID;
          st_d   = S_DONE;
        end else begin
          if (dx_q < 0) begin
            dxa = -{dx_q[WORD_W], dx_q};
            ta  = -{t_q[WORD_W], t_q};
          end else begin
            dxa = {dx_q[WORD_W], dx_q};
            ta  = {t_q[WORD_W], t_q};
          end
          if (ta < 0) ta = '0;
          if (ta > dxa) ta = dxa;
          mt_d  = ta[WORD_W-1:0];
          mdx_d = dxa[WORD_W-1:0];
          neg_d = dv_q[WORD_W];
          mdv_d = dv_q[WORD_W] ? WORD_W'(-dv_q) : dv_q[WORD_W-1:0];
          st_d  = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = PROD_W'(mdv_q) * PROD_W'(mt_q);
        st_d   = S_DIVS;
      end
      S_DIVS: st_d = S_DIVW;
      S_DIVW: begin
        if (div_out.done) begin
          sum = {{2{v0_q[WORD_W-1]}}, v0_q};
          sum = neg_q ? sum - $signed({2'b00, quot}) : sum + $signed({2'b00, quot});
          if (sum > $signed({2'b00, X_MOST_POS}))      res_d = X_MOST_POS;
          else if (sum < $signed({2'b11, X_MOST_NEG})) res_d = X_MOST_NEG;
          else                                         res_d = sum[WORD_W-1:0];
          stat_d = ST_OK;
          st_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d = res_q;
          ou_d = stat_q;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      cnt_q   <= '0;
      least_q <= X_MOST_POS;
      great_q <= X_MOST_NEG;
      chkv_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      least_q <= least_d;
      great_q <= great_d;
      chkv_q  <= chkv_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    req_z_q <= req_z_d; xq_q <= xq_d; iss_q <= iss_d; chk_q <= chk_d;
    idx_q <= idx_d; x0_q <= x0_d; v0_q <= v0_d; x1_q <= x1_d; v1_q <= v1_d;
    dx_q <= dx_d; t_q <= t_d; dv_q <= dv_d; mt_q <= mt_d; mdx_q <= mdx_d;
    mdv_q <= mdv_d; neg_q <= neg_d; prod_q <= prod_d; res_q <= res_d;
    stat_q <= stat_d; od_q <= od_d; ou_q <= ou_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;

endmodule

>>> hdl/plti_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the stream ports of the interpolation unit over time.
// ----------------------------------------------------------------------------
module plti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import plti_pkg::*;

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // One request at a time: no beat is taken right after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // A clear with a free output answers zero and ok via the done state and output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_CLEAR)
      && (!m_axis_tvalid || m_axis_tready)
    |=> ##1 m_axis_tvalid && (m_axis_tdata == '0) && (m_axis_tuser == ST_OK))
    else $error("clear not answered");

  // Full table and short table results carry a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == ST_FULL) || (m_axis_tuser == ST_FEW))
    |-> m_axis_tdata == '0)
    else $error("error status with non-zero value");

endmodule

bind piecewise_linear_table_interp_unit plti_checker u_plti_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

>>> test/piecewise_linear_table_interp_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear table interpolation unit: testbench
// Drives clear, append and query requests over the slave stream and checks
// every result beat against an in-bench table model, with random idling on
// both sides and one long output stall.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_unit_tb;
  import plti_pkg::*;

  localparam int unsigned DEPTH = 256;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  logic [1:0]  s_axis_tuser;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // result_value[31:0]
  logic [1:0]  m_axis_tuser;   // status[1:0]

  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
  } lookup_res_t;

  // Model of the table contents.
  logic signed [31:0] pts_x [DEPTH];
  logic signed [31:0] pts_y [DEPTH];
  logic signed [31:0] pts_z [DEPTH];
  int unsigned        npts;
  logic signed [31:0] lo_x, hi_x;

  lookup_res_t pending_q [$];
  int          fail_cnt;
  bit          idle_on;
  bit          long_stall;

  piecewise_linear_table_interp_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Work out the result of one request and update the table model.
  function automatic lookup_res_t interp_lookup(req_e req, logic signed [31:0] x,
                                                logic signed [31:0] y,
                                                logic signed [31:0] z);
    lookup_res_t       r;
    longint            xq, x0, dx, t, v0, v1, dv, q, acc;
    int unsigned       idx;
    r.value  = '0;
    r.status = ST_OK;
    case (req)
      REQ_CLEAR: begin
        npts = 0;
        lo_x = X_MOST_POS;
        hi_x = X_MOST_NEG;
      end
      REQ_APPEND: begin
        if (npts >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pts_x[npts] = x;
          pts_y[npts] = y;
          pts_z[npts] = z;
          npts++;
          if (x > hi_x) hi_x = x;
          if (x < lo_x) lo_x = x;
        end
      end
      default: begin
        if (npts < 2) begin
          r.status = ST_FEW;
        end else begin
          xq = x;
          if (xq > hi_x) xq = hi_x;
          if (xq < lo_x) xq = lo_x;
          idx = npts - 1;
          for (int unsigned i = 1; i < npts; i++) begin
            if (pts_x[i] >= xq) begin
              idx = i;
              break;
            end
          end
          x0 = pts_x[idx-1];
          dx = longint'(pts_x[idx]) - x0;
          v0 = (req == REQ_QUERYY) ? pts_y[idx-1] : pts_z[idx-1];
          v1 = (req == REQ_QUERYY) ? pts_y[idx] : pts_z[idx];
          if (dx == 0) begin
            r.value  = v0[31:0];
            r.status = ST_ZEROWID;
          end else begin
            t = xq - x0;
            if (dx < 0) begin
              dx = -dx;
              t  = -t;
            end
            if (t < 0) t = 0;
            if (t > dx) t = dx;
            dv = v1 - v0;
            // Both magnitudes stay below 2^32, so the product fits unsigned.
            q = longint'(($unsigned(dv < 0 ? -dv : dv) * $unsigned(t)) / $unsigned(dx));
            acc = (dv < 0) ? v0 - q : v0 + q;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            r.value = acc[31:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  // Offer one request beat; it is predicted once it has been taken.
  task automatic send_req(req_e req, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.insert(pending_q.size(), interp_lookup(req, x, y, z));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Compare each result beat with the oldest prediction.
  initial begin
    lookup_res_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_cnt++;
        end else begin
          exp_r = pending_q.pop_front();
          if (m_axis_tdata !== exp_r.value) begin
            $error("result_value expected %h actual %h", exp_r.value, m_axis_tdata);
            fail_cnt++;
          end
          if (m_axis_tuser !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, m_axis_tuser);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Output back-pressure: random bursts, or one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(negedge clk_i);
        long_stall = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Directed corners: empty table, one point, zero width, extremes, overflow.
  task automatic test_directed();
    send_req(REQ_QUERYY, 32'h0, 32'h0, 32'h0);
    send_req(REQ_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(REQ_QUERYZ, 32'h0, 32'h0, 32'h0);
    send_req(REQ_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(REQ_QUERYY, 32'h0, 32'h0, 32'h0);
    send_req(REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(REQ_QUERYY, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_QUERYZ, 32'h8000_0000, 32'h0, 32'h0);
    send_req(REQ_QUERYZ, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_req(REQ_QUERYY, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_req(REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Descending table, queried between and outside its points.
    send_req(REQ_APPEND, 32'h0005_0000, 32'h0001_0000, 32'h0);
    send_req(REQ_APPEND, 32'h0001_0000, 32'h0009_0000, 32'hFFFF_0000);
    send_req(REQ_QUERYY, 32'h0003_0000, 32'h0, 32'h0);
    send_req(REQ_QUERYZ, 32'h0002_8000, 32'h0, 32'h0);
    send_req(REQ_QUERYY, 32'h0009_0000, 32'h0, 32'h0);
    send_req(REQ_CLEAR,  32'h0, 32'h0, 32'h0);
  endtask

  // Fill the table beyond its depth so the full flag shows.
  task automatic test_full_table();
    send_req(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < DEPTH + 3; i++)
      send_req(REQ_APPEND, 32'(i * 32'h100) - 32'h8000, $urandom, $urandom);
    for (int i = 0; i < 6; i++)
      send_req(req_e'($urandom_range(2, 3)), rand_word(), 32'h0, 32'h0);
  endtask

  // Hold the output off for a long stretch while requests keep coming.
  task automatic test_output_stall();
    long_stall = 1'b1;
    for (int i = 0; i < 8; i++)
      send_req(req_e'($urandom_range(1, 3)), $urandom, $urandom, $urandom);
    wait (!long_stall);
  endtask

  // Random tables, mostly sorted and short, with random queries and noise.
  task automatic test_random_tables(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    logic [31:0] xv;
    sent = 0;
    while (sent < n_items) begin
      send_req(REQ_CLEAR, $urandom, $urandom, $urandom);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 12);
      xv  = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 1000) : $urandom;
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) xv = $urandom;
        else if ($urandom_range(0, 5) != 0) xv = xv + $urandom_range(0, 32'h0100_0000);
        send_req(REQ_APPEND, xv, rand_word(), rand_word());
      end
      for (int unsigned i = 0; i < 8; i++)
        send_req(req_e'($urandom_range(2, 3)), rand_word(), $urandom, $urandom);
      sent += len + 9;
    end
  endtask

  initial begin
    fail_cnt      = 0;
    idle_on       = 1'b1;
    long_stall    = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_CLEAR;
    npts          = 0;
    lo_x          = X_MOST_POS;
    hi_x          = X_MOST_NEG;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_full_table();
    test_output_stall();
    test_random_tables(1220);
    idle_on = 1'b0;
    test_random_tables(200);

    wait (pending_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
